// File: rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, constants and the low-pass tap table of the current-sense
// decimator.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int TAP_COUNT  = 21;
    localparam int GROUP_SIZE = 4;
    localparam int TAP_W      = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    localparam int SAMPLE_W   = 12;
    localparam int CUR_W      = 16;
    localparam int COEF_W     = 16;
    localparam int LEVEL_W    = 32;
    localparam int ACC_W      = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN  = CFG_IDX_W'(1);

    localparam logic [SAMPLE_W-1:0]       ZERO_OFFSET_RESET = SAMPLE_W'(2048);
    localparam logic signed [COEF_W-1:0]  SCALE_GAIN_RESET  = -16'sd1627;

    // single-pole weights in Q15
    localparam logic signed [COEF_W-1:0] STAGE_KEEP = 16'sd31130;
    localparam logic signed [COEF_W-1:0] STAGE_TAKE = 16'sd1638;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_oldest;
        logic [SAMPLE_W-1:0] sample_second;
        logic [SAMPLE_W-1:0] sample_third;
        logic [SAMPLE_W-1:0] sample_newest;
    } in_item_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] fast_current;
        logic signed [CUR_W-1:0] smoothed_current;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAC,
        OP_SCALE,
        OP_FAST,
        OP_L1A,
        OP_L1B,
        OP_L1,
        OP_L2A,
        OP_L2B,
        OP_L2,
        OP_OUT
    } csd_op_t;

    typedef struct packed {
        csd_op_t          op;
        logic [TAP_W-1:0] tap_idx;
    } csd_cmd_t;

    // symmetric low-pass taps in Q1.15, zero past the known ones
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (int'(idx))
            0, 20:   c = -16'sd3;
            1, 19:   c = -16'sd72;
            2, 18:   c = -16'sd209;
            3, 17:   c = -16'sd378;
            4, 16:   c = -16'sd394;
            5, 15:   c = 16'sd17;
            6, 14:   c = 16'sd1059;
            7, 13:   c = 16'sd2677;
            8, 12:   c = 16'sd4497;
            9, 11:   c = 16'sd5943;
            10:      c = 16'sd6495;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/current_sense_decimator.sv
// ----------------------------------------------------------------------------
// current_sense_decimator
// Decimate-by-four low-pass of current-sensor codes, scaled to 1/128 A,
// followed by two cascaded single-pole smoothers.
// ----------------------------------------------------------------------------
//  channel   ports                        carries
//  s_        s_valid s_ready s_data       four 12-bit ADC codes, oldest first
//  m_        m_valid m_ready m_data       fast and smoothed current
//  cfg_      cfg_we cfg_index cfg_wdata   zero offset code, scale gain
//
// one item runs through one accept step, 21 tap steps through the single
// 32x16 multiply-accumulate, 8 scaling and smoothing steps and one output load.
// s_ready is registered and comes up in the cycle after reset is released.
// a finished result waits in the output register while the next item runs;
// that item holds at its output load step until the register is free.
// ----------------------------------------------------------------------------
module current_sense_decimator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  csd_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output csd_pkg::out_item_t                 m_data,
    input  logic                               cfg_we,
    input  logic [csd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    csd_pkg::csd_cmd_t cmd;

    csd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    csd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd)
    );

`ifndef ASSERT_OFF
    // every input transfer loads the history
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (cmd.op == csd_pkg::OP_LOAD))
        else $error("input transfer without history load");

    // tap walk starts at the first tap right after a load
    a_load_then_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == csd_pkg::OP_LOAD) |=> (cmd.op == csd_pkg::OP_MAC && cmd.tap_idx == '0))
        else $error("tap walk did not start at tap zero");

    // a result appears only from the output load step
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(cmd.op) == csd_pkg::OP_OUT))
        else $error("result valid without output load");

    // no input is ready during the tap walk of an item in flight
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == csd_pkg::OP_MAC) |-> !s_ready)
        else $error("input ready during tap walk");
`endif

endmodule

// File: rtl/csd_ctrl.sv
// ----------------------------------------------------------------------------
// csd_ctrl
// Sequencer of the decimator: accept, tap walk, scaling and smoothing steps,
// result load into the output register.
// ----------------------------------------------------------------------------
module csd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output csd_pkg::csd_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_FAST,
        ST_L1A,
        ST_L1B,
        ST_L1,
        ST_L2A,
        ST_L2B,
        ST_L2,
        ST_OUT
    } state_t;

    localparam logic [csd_pkg::TAP_W-1:0] LAST_TAP = csd_pkg::TAP_W'(csd_pkg::TAP_COUNT - 1);

    state_t                     state_reg;
    logic [csd_pkg::TAP_W-1:0]  tap_reg;
    logic                       s_ready_reg;
    logic                       m_valid_reg;
    logic                       out_free;

    // output register can take a result this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        s_ready_reg <= 1'b0;
                        tap_reg     <= '0;
                        state_reg   <= ST_MAC;
                    end else begin
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_MAC: begin
                    tap_reg <= tap_reg + 1'b1;
                    if (tap_reg == LAST_TAP) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: state_reg <= ST_FAST;
                ST_FAST:  state_reg <= ST_L1A;
                ST_L1A:   state_reg <= ST_L1B;
                ST_L1B:   state_reg <= ST_L1;
                ST_L1:    state_reg <= ST_L2A;
                ST_L2A:   state_reg <= ST_L2B;
                ST_L2B:   state_reg <= ST_L2;
                ST_L2:    state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        s_ready_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.tap_idx = tap_reg;
        unique case (state_reg)
            ST_IDLE:  cmd.op = (s_valid && s_ready_reg) ? csd_pkg::OP_LOAD : csd_pkg::OP_NONE;
            ST_MAC:   cmd.op = csd_pkg::OP_MAC;
            ST_SCALE: cmd.op = csd_pkg::OP_SCALE;
            ST_FAST:  cmd.op = csd_pkg::OP_FAST;
            ST_L1A:   cmd.op = csd_pkg::OP_L1A;
            ST_L1B:   cmd.op = csd_pkg::OP_L1B;
            ST_L1:    cmd.op = csd_pkg::OP_L1;
            ST_L2A:   cmd.op = csd_pkg::OP_L2A;
            ST_L2B:   cmd.op = csd_pkg::OP_L2B;
            ST_L2:    cmd.op = csd_pkg::OP_L2;
            ST_OUT:   cmd.op = out_free ? csd_pkg::OP_OUT : csd_pkg::OP_NONE;
            default:  cmd.op = csd_pkg::OP_NONE;
        endcase
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/csd_datapath.sv
// ----------------------------------------------------------------------------
// csd_datapath
// Sample history, shared 32x16 multiply-accumulate, scaling, two IIR levels,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module csd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [csd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  csd_pkg::in_item_t                  s_data,
    output csd_pkg::out_item_t                 m_data,
    input  csd_pkg::csd_cmd_t                  cmd
);

    localparam int MUL_A_W  = csd_pkg::LEVEL_W;
    localparam int ACC_W    = csd_pkg::ACC_W;
    localparam int CUR_W    = csd_pkg::CUR_W;
    localparam int SAMPLE_W = csd_pkg::SAMPLE_W;
    localparam int LEVEL_W  = csd_pkg::LEVEL_W;

    logic [SAMPLE_W-1:0]            hist_reg [csd_pkg::TAP_COUNT];
    logic [SAMPLE_W-1:0]            hist_next [csd_pkg::TAP_COUNT];
    logic [SAMPLE_W-1:0]            group [csd_pkg::GROUP_SIZE];
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [CUR_W-1:0]        fast_reg;
    logic signed [LEVEL_W-1:0]      lvl1_reg;
    logic signed [LEVEL_W-1:0]      lvl2_reg;
    logic [SAMPLE_W-1:0]            zero_offset_reg;
    logic signed [CUR_W-1:0]        gain_reg;
    csd_pkg::out_item_t             out_reg;

    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [csd_pkg::COEF_W-1:0] mul_b;
    logic signed [ACC_W-1:0]        prod;
    logic signed [ACC_W-1:0]        addend;
    logic                           prod_shift;
    logic signed [ACC_W-1:0]        fast_wide;
    logic signed [ACC_W-1:0]        lvl_wide;
    logic signed [ACC_W-1:0]        smooth_wide;

    function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [ACC_W-1:0] v);
        logic signed [CUR_W-1:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[CUR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] sat_lvl(input logic signed [ACC_W-1:0] v);
        logic signed [LEVEL_W-1:0] r;
        if (v > ACC_W'(64'sh7fff_ffff)) begin
            r = 32'sh7fff_ffff;
        end else if (v < -ACC_W'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

    assign group[0] = s_data.sample_newest;
    assign group[1] = s_data.sample_third;
    assign group[2] = s_data.sample_second;
    assign group[3] = s_data.sample_oldest;

    // four samples shift in at once, newest at entry 0
    always_comb begin
        for (int k = 0; k < csd_pkg::TAP_COUNT; k++) begin
            if (k < csd_pkg::GROUP_SIZE) begin
                hist_next[k] = group[k];
            end else begin
                hist_next[k] = hist_reg[k - csd_pkg::GROUP_SIZE];
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        addend     = '0;
        prod_shift = 1'b0;
        case (cmd.op)
            csd_pkg::OP_MAC: begin
                mul_a  = $signed({{(MUL_A_W-SAMPLE_W){1'b0}}, hist_reg[cmd.tap_idx]});
                mul_b  = csd_pkg::tap_coef(cmd.tap_idx);
                addend = acc_reg;
            end
            csd_pkg::OP_SCALE: begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = gain_reg;
            end
            csd_pkg::OP_L1A: begin
                mul_a = lvl1_reg;
                mul_b = csd_pkg::STAGE_KEEP;
            end
            csd_pkg::OP_L1B: begin
                mul_a      = MUL_A_W'(fast_reg);
                mul_b      = csd_pkg::STAGE_TAKE;
                addend     = acc_reg;
                prod_shift = 1'b1;
            end
            csd_pkg::OP_L2A: begin
                mul_a = lvl2_reg;
                mul_b = csd_pkg::STAGE_KEEP;
            end
            csd_pkg::OP_L2B: begin
                mul_a  = lvl1_reg;
                mul_b  = csd_pkg::STAGE_TAKE;
                addend = acc_reg;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half up, then floor shift
    assign fast_wide   = (acc_reg + ACC_W'(64'sd4194304)) >>> 23;
    assign lvl_wide    = (acc_reg + ACC_W'(64'sd16384)) >>> 15;
    assign smooth_wide = (ACC_W'(lvl2_reg) + ACC_W'(64'sd32768)) >>> 16;

    always_comb begin
        acc_next = acc_reg;
        case (cmd.op)
            // offset is preloaded so the tap sum lands as code difference
            csd_pkg::OP_LOAD: acc_next = -{{(ACC_W-SAMPLE_W-15){1'b0}}, zero_offset_reg, 15'b0};
            csd_pkg::OP_MAC, csd_pkg::OP_SCALE, csd_pkg::OP_L1A, csd_pkg::OP_L1B,
            csd_pkg::OP_L2A, csd_pkg::OP_L2B: begin
                acc_next = addend + (prod_shift ? (prod <<< 16) : prod);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < csd_pkg::TAP_COUNT; k++) begin
                hist_reg[k] <= '0;
            end
            lvl1_reg        <= '0;
            lvl2_reg        <= '0;
            zero_offset_reg <= csd_pkg::ZERO_OFFSET_RESET;
            gain_reg        <= csd_pkg::SCALE_GAIN_RESET;
        end else begin
            if (cmd.op == csd_pkg::OP_LOAD) begin
                hist_reg <= hist_next;
            end
            if (cmd.op == csd_pkg::OP_L1) begin
                lvl1_reg <= sat_lvl(lvl_wide);
            end
            if (cmd.op == csd_pkg::OP_L2) begin
                lvl2_reg <= sat_lvl(lvl_wide);
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    csd_pkg::REG_ZERO_OFFSET: zero_offset_reg <= cfg_wdata[SAMPLE_W-1:0];
                    csd_pkg::REG_SCALE_GAIN:  gain_reg        <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.op == csd_pkg::OP_FAST) begin
            fast_reg <= sat_cur(fast_wide);
        end
        if (cmd.op == csd_pkg::OP_OUT) begin
            out_reg.fast_current     <= fast_reg;
            out_reg.smoothed_current <= sat_cur(smooth_wide);
        end
    end

    assign m_data = out_reg;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the current-sense decimator. Groups of four ADC codes
// go in over the input channel. A scoreboard keeps its own filter history,
// scaling and smoothing levels, works out the fast and smoothed current for
// every accepted group, and compares each result transfer against the oldest
// expectation. Register settings change between phases while the block is
// idle. Both channels idle in random bursts but for the fourth and last phases.
// ----------------------------------------------------------------------------
module tb_top;
    import csd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
    localparam int KNOWN_TAPS     = 21;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 233;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    class current_scoreboard;
        logic [SAMPLE_W-1:0]       history[TAP_COUNT];
        int                        level_1;
        int                        level_2;
        logic [SAMPLE_W-1:0]       zero_code;
        logic signed [COEF_W-1:0]  gain;
        int                        weights[KNOWN_TAPS] = '{
            -3, -72, -209, -378, -394, 17, 1059, 2677, 4497, 5943, 6495,
            5943, 4497, 2677, 1059, 17, -394, -378, -209, -72, -3};
        out_item_t                 expected_currents[$];
        int                        fail_count;

        function new();
            foreach (history[k]) history[k] = '0;
            level_1    = 0;
            level_2    = 0;
            zero_code  = ZERO_OFFSET_RESET;
            gain       = SCALE_GAIN_RESET;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ZERO_OFFSET: zero_code = data[SAMPLE_W-1:0];
                REG_SCALE_GAIN:  gain = data;
                default: ;
            endcase
        endfunction

        // floor((v + 2^(s-1)) / 2^s)
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_group(in_item_t g);
            logic [SAMPLE_W-1:0] codes[GROUP_SIZE];
            longint              acc;
            longint              fast;
            longint              lvl;
            out_item_t           res;
            codes = '{g.sample_oldest, g.sample_second, g.sample_third, g.sample_newest};
            foreach (codes[i]) begin
                for (int k = TAP_COUNT - 1; k > 0; k--) history[k] = history[k-1];
                history[0] = codes[i];
            end
            acc = 0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                if (k < KNOWN_TAPS) acc += longint'(weights[k]) * longint'(history[k]);
            end
            acc = (acc - longint'(zero_code) * 32768) * longint'(gain);
            fast = clamp(round_shift(acc, 23), -32768, 32767);
            lvl = longint'(STAGE_KEEP) * longint'(level_1)
                + longint'(STAGE_TAKE) * (fast * 65536);
            level_1 = int'(clamp(round_shift(lvl, 15), -64'sd2147483648, 64'sd2147483647));
            lvl = longint'(STAGE_KEEP) * longint'(level_2)
                + longint'(STAGE_TAKE) * longint'(level_1);
            level_2 = int'(clamp(round_shift(lvl, 15), -64'sd2147483648, 64'sd2147483647));
            res.fast_current     = fast[CUR_W-1:0];
            res.smoothed_current = CUR_W'(clamp(round_shift(longint'(level_2), 16),
                                                -32768, 32767));
            expected_currents.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [CUR_W-1:0] want,
                                    logic signed [CUR_W-1:0] got);
            if (want !== got) begin
                fail_count++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_currents.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got %0d / %0d",
                         $time, got.fast_current, got.smoothed_current);
                return;
            end
            want = expected_currents.pop_front();
            compare_field("fast_current", want.fast_current, got.fast_current);
            compare_field("smoothed_current", want.smoothed_current, got.smoothed_current);
        endfunction

        function int pending();
            return expected_currents.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    current_scoreboard      scoreboard;
    bit                     send_gaps_on;
    bit                     ready_gaps_on;
    int                     stall_left;
    int                     quiet_cycles;

    current_sense_decimator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (!ready_gaps_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) scoreboard.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t group(int unsigned a, int unsigned b, int unsigned c,
                                       int unsigned d);
        in_item_t g;
        g.sample_oldest = a[SAMPLE_W-1:0];
        g.sample_second = b[SAMPLE_W-1:0];
        g.sample_third  = c[SAMPLE_W-1:0];
        g.sample_newest = d[SAMPLE_W-1:0];
        return g;
    endfunction

    function automatic int unsigned near_code(int unsigned centre, int unsigned spread);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_group(in_item_t g);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= g;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_group(g);
        @(negedge aclk);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        scoreboard.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic run_random(int unsigned count, int unsigned centre);
        int unsigned track;
        int unsigned spread;
        in_item_t    g;
        track = centre;
        repeat (count) begin
            if ($urandom_range(0, 15) == 0) track = $urandom_range(0, 4095);
            case ($urandom_range(0, 9))
                0, 1: begin
                    g = group($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
                end
                2: begin
                    g = group(4095 * $urandom_range(0, 1), 4095 * $urandom_range(0, 1),
                              4095 * $urandom_range(0, 1), 4095 * $urandom_range(0, 1));
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       spread = 6;
                        1:       spread = 90;
                        default: spread = 700;
                    endcase
                    g = group(near_code(track, spread), near_code(track, spread),
                              near_code(track, spread), near_code(track, spread));
                end
            endcase
            send_group(g);
        end
    endtask

    logic [CFG_DATA_W-1:0] zero_words[PHASES];
    logic [CFG_DATA_W-1:0] gain_words[PHASES];

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ZERO_OFFSET;
        cfg_wdata     = '0;
        stall_left    = 0;
        quiet_cycles  = 0;
        send_gaps_on  = 1'b1;
        ready_gaps_on = 1'b1;
        scoreboard    = new();

        zero_words = '{16'h0000, 16'hFFFF, 16'd2048, 16'd1000,
                       CFG_DATA_W'($urandom), 16'hA000 | 16'd3000, 16'd2048};
        gain_words = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100,
                       CFG_DATA_W'($urandom), 16'hFF00, 16'(-1627)};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings; first group lands on an empty history
        send_group(group(0, 0, 0, 0));
        repeat (6) send_group(group(4095, 4095, 4095, 4095));
        repeat (6) send_group(group(0, 0, 0, 0));
        repeat (2) send_group(group(12'h555, 12'hAAA, 12'h555, 12'hAAA));
        send_group(group(4095, 0, 0, 0));
        send_group(group(0, 0, 0, 4095));
        repeat (3) send_group(group(2048, 2048, 2048, 2048));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_results();
            send_gaps_on  = (ph != 3) && (ph != PHASES - 1);
            ready_gaps_on = send_gaps_on;
            write_reg(REG_ZERO_OFFSET, zero_words[ph]);
            write_reg(REG_SCALE_GAIN, gain_words[ph]);
            // writes to unused indexes must leave both registers alone
            write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;
            @(negedge aclk);
            run_random(PHASE_ITEMS, 32'(zero_words[ph][SAMPLE_W-1:0]));
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (scoreboard.fail_count == 0 && scoreboard.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
